>>> rtl/rre_pkg.sv
`default_nettype none

package rre_pkg;

   // marker counter width; pool sums and divider widths follow from it
   localparam int MARKER_COUNT_BITS = 24;

   localparam int EC_W   = 16;                      // empirical_count
   localparam int CNT_W  = 32;                      // Q16.16 input counts
   localparam int RATE_W = 17;                      // Q1.16 rates, up to 1.0
   localparam int SIZE_W = MARKER_COUNT_BITS;       // pool sizes
   localparam int ESUM_W = MARKER_COUNT_BITS + 16;  // error pool sum
   localparam int SSUM_W = MARKER_COUNT_BITS + 17;  // switch pool sum
   localparam int NUM_W  = SSUM_W;                  // widest dividend
   localparam int DEN_W  = EC_W + SIZE_W;           // widest divisor
   localparam int DSH_W  = DEN_W + RATE_W - 1;      // divisor shifted to top quotient bit
   localparam int REM_W  = DEN_W + RATE_W;          // partial remainder
   localparam int STEP_W = $clog2(RATE_W + 1);      // divider step counter

   localparam logic [RATE_W-1:0] RATE_MAX = RATE_W'(65536);
   localparam logic [STEP_W-1:0] DIV_STEPS = STEP_W'(RATE_W);

   // divider operand / result destination codes
   localparam logic [1:0] SRC_BG_ERR = 2'd0;
   localparam logic [1:0] SRC_BG_SW  = 2'd1;
   localparam logic [1:0] SRC_IT_ERR = 2'd2;
   localparam logic [1:0] SRC_IT_SW  = 2'd3;

   // pool select for the divisor multiply
   localparam logic POOL_ERR = 1'b0;
   localparam logic POOL_SW  = 1'b1;

   typedef struct packed {
      logic       survey;     // fold accepted survey request into pools
      logic       load;       // capture accepted update request
      logic       mul_en;     // form empirical_count * pool size
      logic       mul_sel;    // which pool size
      logic       div_start;  // launch divider
      logic       store;      // take divider result
      logic [1:0] div_src;    // operands / destination
      logic       emit;       // move result into output register
   } cmd_type;

   typedef struct packed {
      logic div_busy;
      logic bg_ready;
   } status_type;

endpackage

`default_nettype wire

>>> rtl/rre_ctrl.sv
`default_nettype none

module rre_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_tvalid,
   input  wire                  req_action,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  wire                  rsp_tready,
   output rre_pkg::cmd_type     cmd,
   input  rre_pkg::status_type  status
);

   localparam logic [3:0] ST_IDLE      = 4'd0;
   localparam logic [3:0] ST_BGE_MUL   = 4'd1;
   localparam logic [3:0] ST_BGE_START = 4'd2;
   localparam logic [3:0] ST_BGE_WAIT  = 4'd3;
   localparam logic [3:0] ST_BGS_MUL   = 4'd4;
   localparam logic [3:0] ST_BGS_START = 4'd5;
   localparam logic [3:0] ST_BGS_WAIT  = 4'd6;
   localparam logic [3:0] ST_ITE_START = 4'd7;
   localparam logic [3:0] ST_ITE_WAIT  = 4'd8;
   localparam logic [3:0] ST_ITS_START = 4'd9;
   localparam logic [3:0] ST_ITS_WAIT  = 4'd10;
   localparam logic [3:0] ST_EMIT      = 4'd11;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   // sequencer: surveys fold in while idle; backgrounds once per update pass, then the two item quotients
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (!req_action) begin
                  cmd.survey = 1'b1;
               end else begin
                  cmd.load = 1'b1;
                  state_in = status.bg_ready ? ST_ITE_START : ST_BGE_MUL;
               end
            end
         end
         ST_BGE_MUL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = rre_pkg::POOL_ERR;
            state_in    = ST_BGE_START;
         end
         ST_BGE_START: begin
            cmd.div_start = 1'b1;
            cmd.div_src   = rre_pkg::SRC_BG_ERR;
            state_in      = ST_BGE_WAIT;
         end
         ST_BGE_WAIT: begin
            cmd.div_src = rre_pkg::SRC_BG_ERR;
            if (!status.div_busy) begin
               cmd.store = 1'b1;
               state_in  = ST_BGS_MUL;
            end
         end
         ST_BGS_MUL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = rre_pkg::POOL_SW;
            state_in    = ST_BGS_START;
         end
         ST_BGS_START: begin
            cmd.div_start = 1'b1;
            cmd.div_src   = rre_pkg::SRC_BG_SW;
            state_in      = ST_BGS_WAIT;
         end
         ST_BGS_WAIT: begin
            cmd.div_src = rre_pkg::SRC_BG_SW;
            if (!status.div_busy) begin
               cmd.store = 1'b1;
               state_in  = ST_ITE_START;
            end
         end
         ST_ITE_START: begin
            cmd.div_start = 1'b1;
            cmd.div_src   = rre_pkg::SRC_IT_ERR;
            state_in      = ST_ITE_WAIT;
         end
         ST_ITE_WAIT: begin
            cmd.div_src = rre_pkg::SRC_IT_ERR;
            if (!status.div_busy) begin
               cmd.store = 1'b1;
               state_in  = ST_ITS_START;
            end
         end
         ST_ITS_START: begin
            cmd.div_start = 1'b1;
            cmd.div_src   = rre_pkg::SRC_IT_SW;
            state_in      = ST_ITS_WAIT;
         end
         ST_ITS_WAIT: begin
            cmd.div_src = rre_pkg::SRC_IT_SW;
            if (!status.div_busy) begin
               cmd.store = 1'b1;
               state_in  = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output valid: set on emit, dropped when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTH
   // the item error wait state is only reached through its start state
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ITE_WAIT) |->
         ($past(state_ff) == ST_ITE_START || $past(state_ff) == ST_ITE_WAIT))
      else $error("item error wait entered without start");

   // background computation only when backgrounds are stale
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && cmd.load && status.bg_ready) |=>
         (state_ff == ST_ITE_START))
      else $error("backgrounds recomputed while ready");

   // emit never overwrites a result that was not taken
   assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || rsp_tready))
      else $error("output overwritten");
`endif

endmodule

`default_nettype wire

>>> rtl/rre_datapath.sv
`default_nettype none

module rre_datapath (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 csr_wr_en,
   input  wire  [rre_pkg::EC_W-1:0]            csr_wr_data,
   input  wire  [rre_pkg::CNT_W-1:0]           in_error_sum,
   input  wire  [rre_pkg::CNT_W-1:0]           in_switch_sum,
   input  wire                                 in_has_interval,
   input  rre_pkg::cmd_type                    cmd,
   output rre_pkg::status_type                 status,
   output logic [rre_pkg::RATE_W-1:0]          out_error_rate,
   output logic [rre_pkg::RATE_W-1:0]          out_switch_rate,
   output logic                                out_switch_valid,
   output logic                                out_last
);

   localparam int EC_W   = rre_pkg::EC_W;
   localparam int CNT_W  = rre_pkg::CNT_W;
   localparam int RATE_W = rre_pkg::RATE_W;
   localparam int SIZE_W = rre_pkg::SIZE_W;
   localparam int ESUM_W = rre_pkg::ESUM_W;
   localparam int SSUM_W = rre_pkg::SSUM_W;
   localparam int NUM_W  = rre_pkg::NUM_W;
   localparam int DEN_W  = rre_pkg::DEN_W;
   localparam int DSH_W  = rre_pkg::DSH_W;
   localparam int REM_W  = rre_pkg::REM_W;
   localparam int STEP_W = rre_pkg::STEP_W;

   logic [EC_W-1:0]   ec_ff;
   logic [ESUM_W-1:0] err_pool_sum_ff;
   logic [SIZE_W-1:0] err_pool_size_ff;
   logic [SSUM_W-1:0] sw_pool_sum_ff;
   logic [SIZE_W-1:0] sw_pool_size_ff;
   logic [RATE_W-1:0] err_bg_ff, sw_bg_ff;
   logic              bg_ready_ff;

   logic [CNT_W-1:0]  item_err_ff, item_sw_ff;
   logic              item_has_int_ff;
   logic [RATE_W-1:0] erate_ff, srate_ff;
   logic [DEN_W-1:0]  prod_ff;

   logic [REM_W-1:0]  div_rem_ff;
   logic [DSH_W-1:0]  div_dsh_ff;
   logic [RATE_W-1:0] div_q_ff;
   logic [STEP_W-1:0] div_cnt_ff;
   logic              div_sat_ff;

   logic [NUM_W-1:0]  div_num;
   logic [DEN_W-1:0]  div_den;
   logic [REM_W-1:0]  div_num_ext;
   logic              div_ge;
   logic [RATE_W-1:0] div_result;
   logic              err_small, sw_small, it_err_big, it_sw_big;
   logic              clear_pools;
   logic [SIZE_W-1:0] mul_size;

   assign status.div_busy = (div_cnt_ff != '0);
   assign status.bg_ready = bg_ready_ff;

   // thresholds: error below 1.0, switch below 2.0 (Q16.16)
   assign err_small  = (in_error_sum[CNT_W-1:16] == '0);
   assign sw_small   = (in_switch_sum[CNT_W-1:17] == '0);
   assign it_err_big = (item_err_ff[CNT_W-1:16] != '0);
   assign it_sw_big  = (item_sw_ff[CNT_W-1:17] != '0);

   // final marker clears pools as its result leaves
   assign clear_pools = cmd.emit && !item_has_int_ff;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         ec_ff <= EC_W'(1);
      end else if (csr_wr_en) begin
         ec_ff <= csr_wr_data;
      end
   end

   // pools and backgrounds
   always_ff @(posedge clock) begin
      if (reset || clear_pools) begin
         err_pool_sum_ff  <= '0;
         err_pool_size_ff <= '0;
         sw_pool_sum_ff   <= '0;
         sw_pool_size_ff  <= '0;
         err_bg_ff        <= '0;
         sw_bg_ff         <= '0;
         bg_ready_ff      <= 1'b0;
      end else begin
         if (cmd.survey) begin
            if (err_small && (err_pool_size_ff != '1)) begin
               err_pool_sum_ff  <= err_pool_sum_ff + ESUM_W'(in_error_sum);
               err_pool_size_ff <= err_pool_size_ff + SIZE_W'(1);
            end
            if (in_has_interval && sw_small && (sw_pool_size_ff != '1)) begin
               sw_pool_sum_ff  <= sw_pool_sum_ff + SSUM_W'(in_switch_sum);
               sw_pool_size_ff <= sw_pool_size_ff + SIZE_W'(1);
            end
         end
         if (cmd.store && cmd.div_src == rre_pkg::SRC_BG_ERR) begin
            err_bg_ff <= (err_pool_size_ff == '0) ? '0 : div_result;
         end
         if (cmd.store && cmd.div_src == rre_pkg::SRC_BG_SW) begin
            sw_bg_ff    <= (sw_pool_size_ff == '0) ? '0 : div_result;
            bg_ready_ff <= 1'b1;
         end
      end
   end

   // request capture, divisor product and per-item rates
   assign mul_size = (cmd.mul_sel == rre_pkg::POOL_ERR) ? err_pool_size_ff : sw_pool_size_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         item_err_ff     <= in_error_sum;
         item_sw_ff      <= in_switch_sum;
         item_has_int_ff <= in_has_interval;
      end
      if (cmd.mul_en) begin
         prod_ff <= DEN_W'(ec_ff) * DEN_W'(mul_size);
      end
      if (cmd.store && cmd.div_src == rre_pkg::SRC_IT_ERR) begin
         erate_ff <= it_err_big ? div_result : err_bg_ff;
      end
      if (cmd.store && cmd.div_src == rre_pkg::SRC_IT_SW) begin
         srate_ff <= !item_has_int_ff ? '0 : (it_sw_big ? div_result : sw_bg_ff);
      end
      if (cmd.emit) begin
         out_error_rate   <= erate_ff;
         out_switch_rate  <= srate_ff;
         out_switch_valid <= item_has_int_ff;
         out_last         <= !item_has_int_ff;
      end
   end

   // divider operand select
   always_comb begin
      unique case (cmd.div_src)
         rre_pkg::SRC_BG_ERR: begin
            div_num = NUM_W'(err_pool_sum_ff);
            div_den = prod_ff;
         end
         rre_pkg::SRC_BG_SW: begin
            div_num = sw_pool_sum_ff;
            div_den = prod_ff;
         end
         rre_pkg::SRC_IT_ERR: begin
            div_num = NUM_W'(item_err_ff);
            div_den = DEN_W'(ec_ff);
         end
         default: begin
            div_num = NUM_W'(item_sw_ff);
            div_den = DEN_W'(ec_ff);
         end
      endcase
   end

   assign div_num_ext = REM_W'(div_num);
   assign div_ge      = (div_rem_ff >= REM_W'(div_dsh_ff));

   // restoring divider, one quotient bit per cycle; a quotient of 2.0 or more
   // (and a zero divisor) saturates up front
   always_ff @(posedge clock) begin
      if (reset) begin
         div_cnt_ff <= '0;
      end else if (cmd.div_start) begin
         div_cnt_ff <= rre_pkg::DIV_STEPS;
      end else if (div_cnt_ff != '0) begin
         div_cnt_ff <= div_cnt_ff - STEP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         div_rem_ff <= div_num_ext;
         div_dsh_ff <= {div_den, {(RATE_W-1){1'b0}}};
         div_q_ff   <= '0;
         div_sat_ff <= (div_num_ext >= {div_den, {RATE_W{1'b0}}});
      end else if (div_cnt_ff != '0) begin
         if (div_ge) begin
            div_rem_ff <= div_rem_ff - REM_W'(div_dsh_ff);
         end
         div_q_ff   <= {div_q_ff[RATE_W-2:0], div_ge};
         div_dsh_ff <= div_dsh_ff >> 1;
      end
   end

   assign div_result = (div_sat_ff || div_q_ff > rre_pkg::RATE_MAX) ? rre_pkg::RATE_MAX
                                                                     : div_q_ff;

`ifndef SYNTH
   // divider runs its full step count after every start
   assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> (div_cnt_ff == rre_pkg::DIV_STEPS))
      else $error("divider did not start");

   // pool size only shrinks on a final-marker clear
   assert property (@(posedge clock) disable iff (reset)
      !clear_pools |=> (err_pool_size_ff >= $past(err_pool_size_ff)))
      else $error("error pool size decreased");

   // results are taken only from an idle divider and stay within 1.0
   assert property (@(posedge clock) disable iff (reset)
      cmd.store |-> (div_cnt_ff == '0 && div_result <= rre_pkg::RATE_MAX))
      else $error("divider result taken early or out of range");
`endif

endmodule

`default_nettype wire

>>> rtl/rate_reestimate_with_pooling.sv
`default_nettype none

// channel   direction  handshake                payload
// req_*     in         req_tvalid/req_tready    tdata: error_sum, switch_sum; tuser: action, has_interval
// rsp_*     out        rsp_tvalid/rsp_tready    tdata: error_rate, switch_rate; tuser: switch_valid; tlast
// csr_*     in         csr_wr_en                csr_wr_data: empirical_count
//
// A survey request folds into the pools as it is accepted. An update request computes
// two quotients on a shared restoring divider at one bit a cycle.
// The first update request of a pass adds two background quotients before them.
// Synchronous active-high reset clears the pools, backgrounds and control.
// A result waits in the output register; the next request is taken meanwhile
// and stalls only when its own result is ready to leave.

module rate_reestimate_with_pooling (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           req_tvalid,
   output logic                          req_tready,
   input  wire  [63:0]                   req_tdata,   // [31:0] error_sum, [63:32] switch_sum
   input  wire  [1:0]                    req_tuser,   // [0] action, [1] has_interval
   output logic                          rsp_tvalid,
   input  wire                           rsp_tready,
   output logic [39:0]                   rsp_tdata,   // [16:0] error_rate, [33:17] switch_rate
   output logic                          rsp_tuser,   // switch_valid
   output logic                          rsp_tlast,   // last
   input  wire                           csr_wr_en,
   input  wire  [rre_pkg::EC_W-1:0]      csr_wr_data
);

   rre_pkg::cmd_type            cmd;
   rre_pkg::status_type         status;
   logic [rre_pkg::RATE_W-1:0]  error_rate, switch_rate;

   rre_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_action (req_tuser[0]),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   rre_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .in_error_sum     (req_tdata[31:0]),
      .in_switch_sum    (req_tdata[63:32]),
      .in_has_interval  (req_tuser[1]),
      .cmd              (cmd),
      .status           (status),
      .out_error_rate   (error_rate),
      .out_switch_rate  (switch_rate),
      .out_switch_valid (rsp_tuser),
      .out_last         (rsp_tlast)
   );

   assign rsp_tdata = {6'b0, switch_rate, error_rate};

endmodule

`default_nettype wire
